/* sv/mmu_pkg.sv */
// Package for the matrix multiply unit: item structs, action and register
// codes, and the sequencer state type. No dependencies.
package mmu_pkg;

  localparam int IN_VALUE_BITS  = 16;
  localparam int OUT_VALUE_BITS = 36;
  localparam int SIZE_BITS      = 5;
  localparam int IDX_BITS       = 4;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_X = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] CFG_INNER_COUNT = 2'd1;
  localparam logic [1:0] CFG_COL_COUNT   = 2'd2;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]                      action;
    logic [IDX_BITS-1:0]             row_index;
    logic [IDX_BITS-1:0]             col_index;
    logic signed [IN_VALUE_BITS-1:0] element_value;
  } mmu_in_t;

  typedef struct packed {
    logic signed [OUT_VALUE_BITS-1:0] product_value;
    logic                             out_of_range;
  } mmu_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } mmu_state_t;

endpackage

/* sv/matrix_matrix_multiply_unit.sv */
// Matrix multiply unit top level: element stores, config registers and the
// multiply-accumulate sequencer. Depends on mmu_pkg.
//
// Load items (A or X element) are taken and produce no result.
// A read item walks the inner dimension with one shared multiply-accumulate
// per cycle fed by the two element stores, then its result is registered; an
// out-of-range read or an empty inner dimension goes straight to the result.
// The input side is stalled while a read is being computed. The result sits
// in an output register, so a new item can be taken while it waits to be
// collected. Stores hold garbage until written.
module matrix_matrix_multiply_unit
  import mmu_pkg::*;
#(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mmu_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mmu_out_t             out_data
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = 2 * ELEM_BITS;

  logic signed [ELEM_BITS-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [ELEM_BITS-1:0] x_mem [MAX_DIM*MAX_DIM];

  logic [SIZE_BITS-1:0] row_count_r, inner_count_r, col_count_r;
  logic [CNT_W-1:0]     rows_eff, inner_eff, cols_eff;

  mmu_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] a_addr_r, a_addr_nxt;
  logic [ADDR_W-1:0] x_addr_r, x_addr_nxt;
  logic [DIM_W-1:0]  k_r, k_nxt;
  logic signed [OUT_VALUE_BITS-1:0] acc_r, acc_nxt;
  logic oor_r, oor_nxt;
  logic rd_vld_r;
  logic signed [ELEM_BITS-1:0] a_q_r, x_q_r;
  logic signed [PROD_W-1:0]    prod;
  logic out_valid_r, out_valid_nxt;
  mmu_out_t out_data_r, out_data_nxt;

  logic in_accept, out_take;
  logic [ADDR_W-1:0] wr_addr;
  logic signed [ELEM_BITS-1:0] elem;
  logic wr_a, wr_x;
  logic rd_req, rd_oor, rd_start;
  logic last_k;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= SIZE_RESET;
      inner_count_r <= SIZE_RESET;
      col_count_r   <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:   row_count_r   <= cfg_data;
        CFG_INNER_COUNT: inner_count_r <= cfg_data;
        CFG_COL_COUNT:   col_count_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_eff  = (32'(row_count_r) > MAX_DIM)   ? CNT_W'(MAX_DIM) : CNT_W'(row_count_r);
  assign inner_eff = (32'(inner_count_r) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(inner_count_r);
  assign cols_eff  = (32'(col_count_r) > MAX_DIM)   ? CNT_W'(MAX_DIM) : CNT_W'(col_count_r);

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign elem      = ELEM_BITS'(in_data.element_value);
  assign wr_addr   = ADDR_W'(32'(in_data.row_index) * 32'(MAX_DIM) + 32'(in_data.col_index));

  assign wr_a = in_accept && (in_data.action == ACT_LOAD_A)
                && (32'(in_data.row_index) < 32'(rows_eff))
                && (32'(in_data.col_index) < 32'(inner_eff));
  assign wr_x = in_accept && (in_data.action == ACT_LOAD_X)
                && (32'(in_data.row_index) < 32'(inner_eff))
                && (32'(in_data.col_index) < 32'(cols_eff));

  assign rd_req   = in_accept && (in_data.action == ACT_READ);
  assign rd_oor   = (32'(in_data.row_index) >= 32'(rows_eff))
                    || (32'(in_data.col_index) >= 32'(cols_eff));
  assign rd_start = rd_req && !rd_oor && (inner_eff != '0);
  assign last_k   = (32'(k_r) + 32'd1) == 32'(inner_eff);

  // element stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= elem;
    end
    if (wr_x) begin
      x_mem[wr_addr] <= elem;
    end
    a_q_r <= a_mem[a_addr_r];
    x_q_r <= x_mem[x_addr_r];
  end

  assign prod = PROD_W'(a_q_r) * PROD_W'(x_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= (state_r == ST_RUN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r   <= a_addr_nxt;
    x_addr_r   <= x_addr_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    oor_r      <= oor_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    a_addr_nxt    = a_addr_r;
    x_addr_nxt    = x_addr_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_take;
    out_data_nxt  = out_data_r;
    if (rd_vld_r) begin
      acc_nxt = acc_r + OUT_VALUE_BITS'(prod);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (rd_start) begin
          a_addr_nxt = ADDR_W'(32'(in_data.row_index) * 32'(MAX_DIM));
          x_addr_nxt = ADDR_W'(in_data.col_index);
          k_nxt      = '0;
          acc_nxt    = '0;
          oor_nxt    = 1'b0;
          state_nxt  = ST_RUN;
        end else if (rd_req) begin
          acc_nxt   = '0;
          oor_nxt   = rd_oor;
          state_nxt = ST_FINISH;
        end
      end
      ST_RUN: begin
        a_addr_nxt = a_addr_r + ADDR_W'(1);
        x_addr_nxt = x_addr_r + ADDR_W'(MAX_DIM);
        k_nxt      = k_r + DIM_W'(1);
        if (last_k) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.product_value = acc_r;
          out_data_nxt.out_of_range  = oor_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while a read is in progress");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_of_range) |-> (out_data_r.product_value == '0))
    else $error("out-of-range result carries a nonzero value");

  a_mac_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == ST_RUN))
    else $error("accumulate without a preceding store read");

  a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
    rd_start |=> (state_r == ST_RUN))
    else $error("in-range read did not start the inner walk");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && state_nxt == ST_IDLE) |=> out_valid_r)
    else $error("finished read did not present a result");
`endif

endmodule
